[hw/rtl/cfd_pkg.sv]
// Package for the command frame deframer: parse phases, field widths,
// register map and the frame hand-off struct. No dependencies.
package cfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_OUT_W  = 6;
    localparam int POS_W      = 5;
    localparam int HELD_LEN_W = 7;
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;

    localparam logic [BYTE_W-1:0] IDLE_SAT = 8'hFF;

    localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [1:0] REG_IDLE_LIMIT    = 2'd2;

    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h55;
    localparam logic [BYTE_W-1:0] IDLE_LIMIT_RST    = 8'd5;

    typedef enum logic [5:0] {
        PH_HDR1 = 6'b000001,
        PH_HDR2 = 6'b000010,
        PH_CMD  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_SUM  = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        E_IDLE = 3'b001,
        E_READ = 3'b010,
        E_LOAD = 3'b100
    } emit_state_t;

    // Good frame from the parser to the readout engine
    typedef struct packed {
        logic                  valid;
        logic [BYTE_W-1:0]     command;
        logic [HELD_LEN_W-1:0] length;
    } frame_t;

    typedef struct packed {
        logic [BYTE_W-1:0] first_header;
        logic [BYTE_W-1:0] second_header;
        logic [BYTE_W-1:0] idle_limit;
    } cfg_t;

endpackage

[hw/rtl/cfd_channels.sv]
// Valid/ready channel interfaces for the deframer input and result words.
// Depends on cfd_pkg for field widths.
interface cfd_in_if
    import cfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface cfd_out_if
    import cfd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    frame_command;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [BYTE_W-1:0]    payload_byte;
    logic [POS_W-1:0]     byte_position;
    logic                 last_of_run;

    modport source (output valid, output frame_command, output frame_length,
                    output payload_byte, output byte_position, output last_of_run,
                    input ready);
    modport sink   (input valid, input frame_command, input frame_length,
                    input payload_byte, input byte_position, input last_of_run,
                    output ready);
endinterface

[hw/rtl/cfd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cfd_parser.sv]
// Frame parser: header hunt, checksum, idle timeout, payload writes to the RAM.
// Depends on cfd_pkg.
module cfd_parser
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           accept,
    input  logic                           cmd,
    input  logic [BYTE_W-1:0]              rx_byte,
    output logic                           ram_we,
    output logic [$clog2(PAYLOAD_MAX)-1:0] ram_waddr,
    output logic [BYTE_W-1:0]              ram_wdata,
    output frame_t                         frame
);

    localparam int AW = $clog2(PAYLOAD_MAX);
    localparam int FW = $clog2(PAYLOAD_MAX + 1);

    phase_t                phase_reg, phase_next;
    logic [BYTE_W-1:0]     command_reg, command_next;
    logic [HELD_LEN_W-1:0] length_reg, length_next;
    logic [FW-1:0]         fill_reg, fill_next;
    logic [BYTE_W-1:0]     xor_reg, xor_next;
    logic [BYTE_W-1:0]     idle_reg, idle_next;
    logic [BYTE_W-1:0]     idle_inc;
    logic [FW-1:0]         fill_inc;

    assign idle_inc  = (idle_reg == IDLE_SAT) ? IDLE_SAT : idle_reg + 8'd1;
    assign fill_inc  = fill_reg + FW'(1);
    assign ram_waddr = fill_reg[AW-1:0];
    assign ram_wdata = rx_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        fill_next     = fill_reg;
        xor_next      = xor_reg;
        idle_next     = idle_reg;
        ram_we        = 1'b0;
        frame.valid   = 1'b0;
        frame.command = command_reg;
        frame.length  = length_reg;
        if (accept)
        begin
            if (cmd)
            begin
                if (phase_reg != PH_HDR1)
                begin
                    if (idle_inc > cfg.idle_limit)
                    begin
                        // timeout: drop the partial frame
                        phase_next   = PH_HDR1;
                        command_next = '0;
                        length_next  = '0;
                        fill_next    = '0;
                        xor_next     = '0;
                        idle_next    = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            else
            begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        if (rx_byte == cfg.first_header)
                        begin
                            xor_next   = rx_byte;
                            phase_next = PH_HDR2;
                        end
                    end
                    PH_HDR2:
                    begin
                        if (rx_byte == cfg.second_header)
                        begin
                            xor_next   = xor_reg ^ rx_byte;
                            phase_next = PH_CMD;
                        end
                        else if (rx_byte == cfg.first_header)
                        begin
                            xor_next = rx_byte;
                        end
                        else
                        begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_CMD:
                    begin
                        command_next = rx_byte;
                        xor_next     = xor_reg ^ rx_byte;
                        phase_next   = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        xor_next  = xor_reg ^ rx_byte;
                        fill_next = '0;
                        if (rx_byte > BYTE_W'(PAYLOAD_MAX))
                        begin
                            phase_next = PH_HDR1;
                        end
                        else
                        begin
                            length_next = rx_byte[HELD_LEN_W-1:0];
                            phase_next  = (rx_byte == '0) ? PH_SUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_inc;
                        xor_next  = xor_reg ^ rx_byte;
                        if (HELD_LEN_W'(fill_inc) >= length_reg)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        frame.valid = (rx_byte == xor_reg);
                        phase_next  = PH_HDR1;
                    end
                    default:
                    begin
                        phase_next = PH_HDR1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR1;
            command_reg <= '0;
            length_reg  <= '0;
            fill_reg    <= '0;
            xor_reg     <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            fill_reg    <= fill_next;
            xor_reg     <= xor_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

[hw/rtl/cfd_emit.sv]
// Readout engine: reads a good frame's payload from the RAM and drives the
// result channel through an output register. Depends on cfd_pkg, cfd_out_if.
module cfd_emit
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frame_t                         frame,
    output logic                           busy,
    output logic                           ram_re,
    output logic [$clog2(PAYLOAD_MAX)-1:0] ram_raddr,
    input  logic [BYTE_W-1:0]              ram_rdata,
    cfd_out_if.source                      out_ch
);

    localparam int AW = $clog2(PAYLOAD_MAX);
    localparam int FW = $clog2(PAYLOAD_MAX + 1);

    emit_state_t           state_reg, state_next;
    logic [FW-1:0]         idx_reg, idx_next;
    logic                  empty_reg, empty_next;
    logic [BYTE_W-1:0]     command_reg, command_next;
    logic [HELD_LEN_W-1:0] length_reg, length_next;
    logic                  ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0]     ocmd_reg, ocmd_next;
    logic [LEN_OUT_W-1:0]  olen_reg, olen_next;
    logic [BYTE_W-1:0]     obyte_reg, obyte_next;
    logic [POS_W-1:0]      opos_reg, opos_next;
    logic                  olast_reg, olast_next;
    logic                  out_free;
    logic                  is_last;
    logic [FW-1:0]         idx_inc;
    logic [POS_W+FW-1:0]   idx_wide;

    assign out_free  = !ovalid_reg || out_ch.ready;
    assign idx_inc   = idx_reg + FW'(1);
    assign idx_wide  = {{POS_W{1'b0}}, idx_reg};
    assign is_last   = empty_reg || (HELD_LEN_W'(idx_inc) == length_reg);
    assign ram_re    = (state_reg == E_READ);
    assign ram_raddr = idx_reg[AW-1:0];
    assign busy      = (state_reg != E_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        empty_next   = empty_reg;
        command_next = command_reg;
        length_next  = length_reg;
        ovalid_next  = ovalid_reg && !out_ch.ready;
        ocmd_next    = ocmd_reg;
        olen_next    = olen_reg;
        obyte_next   = obyte_reg;
        opos_next    = opos_reg;
        olast_next   = olast_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (frame.valid)
                begin
                    idx_next     = '0;
                    command_next = frame.command;
                    length_next  = frame.length;
                    empty_next   = (frame.length == '0);
                    state_next   = (frame.length == '0) ? E_LOAD : E_READ;
                end
            end
            E_READ:
            begin
                state_next = E_LOAD;
            end
            E_LOAD:
            begin
                // hold the RAM word until the output register frees up
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ocmd_next   = command_reg;
                    olen_next   = length_reg[LEN_OUT_W-1:0];
                    obyte_next  = empty_reg ? '0 : ram_rdata;
                    opos_next   = idx_wide[POS_W-1:0];
                    olast_next  = is_last;
                    idx_next    = idx_inc;
                    state_next  = is_last ? E_IDLE : E_READ;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        length_reg  <= length_next;
        ocmd_reg    <= ocmd_next;
        olen_reg    <= olen_next;
        obyte_reg   <= obyte_next;
        opos_reg    <= opos_next;
        olast_reg   <= olast_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.frame_command = ocmd_reg;
    assign out_ch.frame_length  = olen_reg;
    assign out_ch.payload_byte  = obyte_reg;
    assign out_ch.byte_position = opos_reg;
    assign out_ch.last_of_run   = olast_reg;

endmodule

[hw/rtl/command_frame_deframer_unit.sv]
// Top level of the command frame deframer: APB registers, parser, payload RAM
// and readout engine. Depends on cfd_pkg, cfd_channels, cfd_ram, cfd_parser, cfd_emit.
//
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     cmd, rx_byte
//  out_ch    out  valid/ready     frame_command, frame_length, payload_byte,
//                                 byte_position, last_of_run
//  apb       in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// An input word (byte or tick) is taken whenever in_ch.valid is high and the engine is idle.
// A good checksum byte hands the frame to the readout engine; in_ch.ready stays
// low while it works: a RAM read state, then an output load state, per payload
// byte, and only the load state for an empty payload; loading waits on out_ch.ready.
// The last result word may still sit in the output register when input resumes.
// rst_n clears the parser, the engine and the registers; the RAM needs no clear.
module command_frame_deframer_unit
    import cfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    cfd_in_if.sink            in_ch,
    cfd_out_if.source         out_ch
);

    localparam int AW = $clog2(PAYLOAD_MAX);

    cfg_t              cfg_reg;
    frame_t            frame;
    logic              busy;
    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_header  <= FIRST_HEADER_RST;
            cfg_reg.second_header <= SECOND_HEADER_RST;
            cfg_reg.idle_limit    <= IDLE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FIRST_HEADER:  cfg_reg.first_header  <= pwdata[BYTE_W-1:0];
                REG_SECOND_HEADER: cfg_reg.second_header <= pwdata[BYTE_W-1:0];
                REG_IDLE_LIMIT:    cfg_reg.idle_limit    <= pwdata[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FIRST_HEADER:  prdata = CFG_DW'(cfg_reg.first_header);
            REG_SECOND_HEADER: prdata = CFG_DW'(cfg_reg.second_header);
            REG_IDLE_LIMIT:    prdata = CFG_DW'(cfg_reg.idle_limit);
            default:           prdata = '0;
        endcase
    end

    // stall input while a frame is read out
    assign in_ch.ready = !busy;
    assign accept      = in_ch.valid && !busy;

    cfd_parser #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .cmd      (in_ch.cmd),
        .rx_byte  (in_ch.rx_byte),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .frame    (frame)
    );

    cfd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PAYLOAD_MAX)
    ) u_payload_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    cfd_emit #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .busy     (busy),
        .ram_re   (ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata),
        .out_ch   (out_ch)
    );

endmodule
